// ===== hw/rtl/rpuv_pkg.sv =====
// ----------------------------------------------------------------------------
// Relative path validator package
// Widths, register map, byte codes and beat types shared by the path
// validator, its channel interfaces and its checker.
// ----------------------------------------------------------------------------
package rpuv_pkg;

  localparam int CNT_W = 11;
  localparam logic [CNT_W-1:0] CNT_MAX      = '1;
  localparam logic [CNT_W-1:0] MAX_PATH_RST = 11'd1024;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  // Register select is paddr[2]; the low two bits are the byte offset.
  localparam logic REG_MAX_PATH = 1'b0;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_ONE    = 8'h31;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_Z  = 8'h7a;

  localparam logic [23:0] DEV_CON = "CON";
  localparam logic [23:0] DEV_PRN = "PRN";
  localparam logic [23:0] DEV_AUX = "AUX";
  localparam logic [23:0] DEV_NUL = "NUL";
  localparam logic [23:0] DEV_COM = "COM";
  localparam logic [23:0] DEV_LPT = "LPT";

  localparam logic [20:0] CP_MIN_2B = 21'h00080;
  localparam logic [20:0] CP_MIN_3B = 21'h00800;
  localparam logic [20:0] CP_MIN_4B = 21'h10000;
  localparam logic [20:0] CP_MAX    = 21'h10ffff;
  localparam logic [20:0] CP_SUR_LO = 21'h0d800;
  localparam logic [20:0] CP_SUR_HI = 21'h0dfff;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       byte_present;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic             path_ok;
    logic [CNT_W-1:0] byte_total;
  } out_beat_t;

endpackage

// ===== hw/rtl/rpuv_if.sv =====
// ----------------------------------------------------------------------------
// Path validator channel interfaces
// Valid/ready channels for path bytes in and verdicts out.
// ----------------------------------------------------------------------------
interface rpuv_in_if;
  import rpuv_pkg::*;

  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       byte_present;
  logic       last_byte;

  modport source (output valid, output char_byte, output byte_present,
                  output last_byte, input ready);
  modport sink (input valid, input char_byte, input byte_present,
                input last_byte, output ready);
endinterface

interface rpuv_out_if;
  import rpuv_pkg::*;

  logic             valid;
  logic             ready;
  logic             path_ok;
  logic [CNT_W-1:0] byte_total;

  modport source (output valid, output path_ok, output byte_total, input ready);
  modport sink (input valid, input path_ok, input byte_total, output ready);
endinterface

// ===== hw/rtl/relative_path_utf8_validator.sv =====
// ----------------------------------------------------------------------------
// Relative path UTF-8 validator
// A verdict is registered in the result stage when the last beat of a path leaves the input stage.
// Throughput: one beat per cycle while the input stage is not stalled.
// The input stage only stalls when a verdict waits behind an untaken one.
// Reset (synchronous, rst_n low) clears all path state, both pipeline stages
// and sets max_path_r to 1024.
// ----------------------------------------------------------------------------
module relative_path_utf8_validator (
  input  logic                         clk,
  input  logic                         rst_n,
  rpuv_in_if.sink                      in_if,
  rpuv_out_if.source                   out_if,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rpuv_pkg::CFG_AW-1:0]  paddr,
  input  logic [rpuv_pkg::CFG_DW-1:0]  pwdata,
  output logic [rpuv_pkg::CFG_DW-1:0]  prdata,
  output logic                         pready
);
  import rpuv_pkg::*;

  logic [CNT_W-1:0] max_path_r;

  in_beat_t  s1_r;
  logic      s1_vld_r;
  logic      s1_adv;
  out_beat_t out_r;
  out_beat_t out_nxt;
  logic      out_vld_r;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]       pend_r, pend_nxt;
  logic [1:0]       seq_r, seq_nxt;
  logic [20:0]      cp_r, cp_nxt;
  logic [2:0]       clen_r, clen_nxt;
  logic [31:0]      head_r, head_nxt;
  logic [2:0]       dot_r, dot_nxt;
  logic             aslash_r, aslash_nxt;
  logic             fail_r, fail_nxt;

  function automatic logic [7:0] fold_upper(input logic [7:0] c);
    if (c >= CH_LOW_A && c <= CH_LOW_Z) begin
      return c - 8'h20;
    end
    return c;
  endfunction

  function automatic logic comp_bad(input logic aslash, input logic [2:0] clen,
                                    input logic [31:0] head, input logic [2:0] dot);
    logic [2:0]  stem_len;
    logic [23:0] three;
    logic [7:0]  c3;
    logic        bad;
    stem_len = (dot != 3'd0) ? dot : clen;
    three    = {fold_upper(head[7:0]), fold_upper(head[15:8]), fold_upper(head[23:16])};
    c3       = fold_upper(head[31:24]);
    bad      = aslash;
    if (clen == 3'd1 && head[7:0] == CH_DOT) begin
      bad = 1'b1;
    end
    if (clen == 3'd2 && head[15:0] == {CH_DOT, CH_DOT}) begin
      bad = 1'b1;
    end
    if (stem_len == 3'd3 && (three == DEV_CON || three == DEV_PRN ||
                             three == DEV_AUX || three == DEV_NUL)) begin
      bad = 1'b1;
    end
    if (stem_len == 3'd4 && (three == DEV_COM || three == DEV_LPT) &&
        c3 >= CH_ONE && c3 <= CH_NINE) begin
      bad = 1'b1;
    end
    return bad;
  endfunction

  function automatic logic cp_bad(input logic [20:0] cp, input logic [1:0] seq);
    logic [20:0] minimum;
    unique case (seq)
      2'd1:    minimum = CP_MIN_2B;
      2'd2:    minimum = CP_MIN_3B;
      default: minimum = CP_MIN_4B;
    endcase
    return (cp < minimum) || (cp > CP_MAX) || (cp >= CP_SUR_LO && cp <= CP_SUR_HI);
  endfunction

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MAX_PATH) ? CFG_DW'(max_path_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_path_r <= MAX_PATH_RST;
    end else if (psel && penable && pwrite && paddr[2] == REG_MAX_PATH) begin
      max_path_r <= pwdata[CNT_W-1:0];
    end
  end

  // Input stage
  assign s1_adv      = s1_vld_r && (!s1_r.last_byte || !out_vld_r || out_if.ready);
  assign in_if.ready = !s1_vld_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_if.valid && in_if.ready) begin
      s1_vld_r <= 1'b1;
    end else if (s1_adv) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      s1_r <= '{char_byte: in_if.char_byte, byte_present: in_if.byte_present,
                last_byte: in_if.last_byte};
    end
  end

  // Path state update
  always_comb begin
    logic [7:0] b;
    logic       lead;
    b          = s1_r.char_byte;
    lead       = 1'b1;
    cnt_nxt    = cnt_r;
    pend_nxt   = pend_r;
    seq_nxt    = seq_r;
    cp_nxt     = cp_r;
    clen_nxt   = clen_r;
    head_nxt   = head_r;
    dot_nxt    = dot_r;
    aslash_nxt = aslash_r;
    fail_nxt   = fail_r;
    out_nxt    = '{path_ok: 1'b0, byte_total: '0};

    if (s1_r.byte_present) begin
      if (cnt_r != CNT_MAX) begin
        cnt_nxt = cnt_r + 1'b1;
      end
      if (b == CH_NUL || b == CH_BSLASH) begin
        fail_nxt = 1'b1;
      end

      if (pend_r != 2'd0) begin
        if (b[7:6] == 2'b10) begin
          lead     = 1'b0;
          cp_nxt   = {cp_r[14:0], b[5:0]};
          pend_nxt = pend_r - 1'b1;
          if (pend_nxt == 2'd0 && cp_bad(cp_nxt, seq_r)) begin
            fail_nxt = 1'b1;
          end
        end else begin
          fail_nxt = 1'b1;
          pend_nxt = 2'd0;
        end
      end
      if (lead && b[7]) begin
        priority if (b[7:5] == 3'b110) begin
          cp_nxt   = {16'd0, b[4:0]};
          seq_nxt  = 2'd1;
          pend_nxt = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
          cp_nxt   = {17'd0, b[3:0]};
          seq_nxt  = 2'd2;
          pend_nxt = 2'd2;
        end else if (b[7:3] == 5'b11110) begin
          cp_nxt   = {18'd0, b[2:0]};
          seq_nxt  = 2'd3;
          pend_nxt = 2'd3;
        end else begin
          fail_nxt = 1'b1;
        end
      end

      if (b == CH_SLASH) begin
        if (comp_bad(aslash_r, clen_r, head_r, dot_r)) begin
          fail_nxt = 1'b1;
        end
        aslash_nxt = 1'b1;
        clen_nxt   = 3'd0;
        head_nxt   = '0;
        dot_nxt    = 3'd0;
      end else begin
        if (!clen_r[2]) begin
          head_nxt[{clen_r[1:0], 3'b000} +: 8] = head_r[{clen_r[1:0], 3'b000} +: 8] | b;
        end
        if (b == CH_DOT && clen_r != 3'd0) begin
          dot_nxt = clen_r;
        end
        if (clen_r != 3'd7) begin
          clen_nxt = clen_r + 1'b1;
        end
        aslash_nxt = 1'b0;
      end
    end

    if (s1_r.last_byte) begin
      if (pend_nxt != 2'd0 || comp_bad(aslash_nxt, clen_nxt, head_nxt, dot_nxt) ||
          cnt_nxt > max_path_r) begin
        fail_nxt = 1'b1;
      end
      out_nxt    = '{path_ok: !fail_nxt, byte_total: cnt_nxt};
      cnt_nxt    = '0;
      pend_nxt   = 2'd0;
      seq_nxt    = 2'd0;
      cp_nxt     = '0;
      clen_nxt   = 3'd0;
      head_nxt   = '0;
      dot_nxt    = 3'd0;
      aslash_nxt = 1'b1;
      fail_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      pend_r   <= 2'd0;
      seq_r    <= 2'd0;
      cp_r     <= '0;
      clen_r   <= 3'd0;
      head_r   <= '0;
      dot_r    <= 3'd0;
      aslash_r <= 1'b1;
      fail_r   <= 1'b0;
    end else if (s1_adv) begin
      cnt_r    <= cnt_nxt;
      pend_r   <= pend_nxt;
      seq_r    <= seq_nxt;
      cp_r     <= cp_nxt;
      clen_r   <= clen_nxt;
      head_r   <= head_nxt;
      dot_r    <= dot_nxt;
      aslash_r <= aslash_nxt;
      fail_r   <= fail_nxt;
    end
  end

  // Result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_adv && s1_r.last_byte) begin
      out_vld_r <= 1'b1;
    end else if (out_if.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_r.last_byte) begin
      out_r <= out_nxt;
    end
  end

  assign out_if.valid      = out_vld_r;
  assign out_if.path_ok    = out_r.path_ok;
  assign out_if.byte_total = out_r.byte_total;

endmodule

// ===== hw/rtl/rpuv_chk.sv =====
// ----------------------------------------------------------------------------
// Path validator port checker
// Watches the ports of the path validator and flags illegal behaviour.
// ----------------------------------------------------------------------------
module rpuv_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        path_ok,
  input logic [rpuv_pkg::CNT_W-1:0]  byte_total,
  input logic                        pready
);
  import rpuv_pkg::*;

  // A stalled verdict beat keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(path_ok) && $stable(byte_total))
    else $error("verdict beat changed while stalled");

  // A path with no bytes never passes.
  a_empty_fails: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && byte_total == '0 |-> !path_ok)
    else $error("empty path reported as valid");

  // The input only stalls behind a verdict that is waiting to be taken.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a waiting verdict");

  // No verdict is shown in the cycle after reset.
  a_reset_clear: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("verdict valid straight after reset");

  a_pready: assert property (@(posedge clk) pready)
    else $error("configuration port not ready");

endmodule

bind relative_path_utf8_validator rpuv_chk u_rpuv_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_if.ready),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .path_ok    (out_if.path_ok),
  .byte_total (out_if.byte_total),
  .pready     (pready)
);

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// Relative path validator testbench
// Sends paths one byte beat at a time into the validator. A predictor in the
// bench applies the UTF-8, separator, dot, device-name and length rules to
// each accepted beat, and every verdict is compared field by field with the
// oldest pending prediction. Directed paths and length limits come first,
// then random paths under four idling and stalling patterns.
// ----------------------------------------------------------------------------
module tb_top;
  import rpuv_pkg::*;

  localparam logic [CFG_AW-1:0] ADDR_MAX_PATH = {REG_MAX_PATH, 2'b00};
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 6;
  localparam int PHASE_BEATS    = 180;

  logic clk = 1'b0;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic pready;

  rpuv_in_if  in_if ();
  rpuv_out_if out_if ();

  relative_path_utf8_validator u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_if),
    .out_if  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  int sender_idle_pct = 0;
  int sink_stall_pct  = 0;
  int mismatches      = 0;
  int path_beats      = 0;
  int verdicts_seen   = 0;
  int quiet_cycles    = 0;

  out_beat_t expected_verdicts[$];
  logic [7:0] path_bytes[$];

  // Predictor state for the path being received.
  logic [CNT_W-1:0] max_path_len = MAX_PATH_RST;
  logic [CNT_W-1:0] seen_bytes;
  logic [1:0]       cont_left;
  logic [1:0]       seq_conts;
  logic [20:0]      cp_acc;
  logic [2:0]       name_len;
  logic [31:0]      name_head;
  logic [2:0]       last_dot;
  logic             at_sep;
  logic             path_bad;

  function automatic void clear_path_state();
    seen_bytes = '0;
    cont_left  = '0;
    seq_conts  = '0;
    cp_acc     = '0;
    name_len   = '0;
    name_head  = '0;
    last_dot   = '0;
    at_sep     = 1'b1;
    path_bad   = 1'b0;
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    return (c >= CH_LOW_A && c <= CH_LOW_Z) ? c - 8'h20 : c;
  endfunction

  function automatic logic device_stem();
    logic [2:0]  stem;
    logic [23:0] head3;
    logic [7:0]  digit;
    stem  = (last_dot != 0) ? last_dot : name_len;
    head3 = {to_upper(name_head[7:0]), to_upper(name_head[15:8]),
             to_upper(name_head[23:16])};
    digit = to_upper(name_head[31:24]);
    if (stem == 3'd3)
      return head3 == DEV_CON || head3 == DEV_PRN || head3 == DEV_AUX || head3 == DEV_NUL;
    if (stem == 3'd4)
      return (head3 == DEV_COM || head3 == DEV_LPT) && digit >= CH_ONE && digit <= CH_NINE;
    return 1'b0;
  endfunction

  function automatic void close_name();
    if (at_sep) begin
      path_bad = 1'b1;
      return;
    end
    if (name_len == 3'd1 && name_head[7:0] == CH_DOT)
      path_bad = 1'b1;
    if (name_len == 3'd2 && name_head[15:0] == {CH_DOT, CH_DOT})
      path_bad = 1'b1;
    if (device_stem())
      path_bad = 1'b1;
  endfunction

  function automatic void check_scalar();
    logic [20:0] lowest;
    lowest = (seq_conts == 2'd1) ? CP_MIN_2B : (seq_conts == 2'd2) ? CP_MIN_3B : CP_MIN_4B;
    if (cp_acc < lowest || cp_acc > CP_MAX || (cp_acc >= CP_SUR_LO && cp_acc <= CP_SUR_HI))
      path_bad = 1'b1;
  endfunction

  function automatic void decode_utf8(input logic [7:0] b);
    if (cont_left != 0) begin
      if (b[7:6] == 2'b10) begin
        cp_acc    = {cp_acc[14:0], b[5:0]};
        cont_left = cont_left - 2'd1;
        if (cont_left == 0)
          check_scalar();
        return;
      end
      path_bad  = 1'b1;
      cont_left = '0;
    end
    if (!b[7])
      return;
    if (b[7:5] == 3'b110) begin
      cp_acc    = {16'd0, b[4:0]};
      seq_conts = 2'd1;
    end else if (b[7:4] == 4'b1110) begin
      cp_acc    = {17'd0, b[3:0]};
      seq_conts = 2'd2;
    end else if (b[7:3] == 5'b11110) begin
      cp_acc    = {18'd0, b[2:0]};
      seq_conts = 2'd3;
    end else begin
      path_bad = 1'b1;
      return;
    end
    cont_left = seq_conts;
  endfunction

  function automatic void take_path_byte(input logic [7:0] b);
    if (seen_bytes != CNT_MAX)
      seen_bytes = seen_bytes + 1'b1;
    if (b == CH_NUL || b == CH_BSLASH)
      path_bad = 1'b1;
    decode_utf8(b);
    if (b == CH_SLASH) begin
      close_name();
      at_sep    = 1'b1;
      name_len  = '0;
      name_head = '0;
      last_dot  = '0;
      return;
    end
    if (name_len < 3'd4)
      name_head[8*name_len +: 8] = b;
    if (b == CH_DOT && name_len >= 3'd1)
      last_dot = name_len;
    if (name_len < 3'd7)
      name_len = name_len + 3'd1;
    at_sep = 1'b0;
  endfunction

  function automatic logic verdict_for_beat(input in_beat_t beat, output out_beat_t verdict);
    verdict = '0;
    if (beat.byte_present)
      take_path_byte(beat.char_byte);
    if (!beat.last_byte)
      return 1'b0;
    if (cont_left != 0)
      path_bad = 1'b1;
    close_name();
    if (seen_bytes > max_path_len)
      path_bad = 1'b1;
    verdict.path_ok    = !path_bad;
    verdict.byte_total = seen_bytes;
    clear_path_state();
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin : check_verdicts
    out_beat_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_verdicts.size() == 0) begin
        $error("Verdict with no path pending: path_ok %0d, byte_total %0d",
               out_if.path_ok, out_if.byte_total);
        mismatches++;
      end else begin
        want = expected_verdicts.pop_front();
        verdicts_seen++;
        if (out_if.path_ok !== want.path_ok) begin
          $error("path_ok: expected %0d, got %0d", want.path_ok, out_if.path_ok);
          mismatches++;
        end
        if (out_if.byte_total !== want.byte_total) begin
          $error("byte_total: expected %0d, got %0d", want.byte_total, out_if.byte_total);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input logic [7:0] value, input logic present, input logic last);
    in_beat_t  beat;
    out_beat_t verdict;
    beat = '{char_byte: value, byte_present: present, last_byte: last};
    while ($urandom_range(99) < sender_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.char_byte    <= value;
    in_if.byte_present <= present;
    in_if.last_byte    <= last;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    if (verdict_for_beat(beat, verdict))
      expected_verdicts = {expected_verdicts, verdict};
    if (present || last)
      path_beats++;
  endtask

  task automatic send_path(input bit end_marker, input bit idle_gaps);
    int n;
    n = path_bytes.size();
    for (int i = 0; i < n; i++) begin
      if (idle_gaps && $urandom_range(14) == 0)
        send_item(8'($urandom_range(255)), 1'b0, 1'b0);
      send_item(path_bytes[i], 1'b1, !end_marker && i == n - 1);
    end
    if (end_marker || n == 0)
      send_item(8'($urandom_range(255)), 1'b0, 1'b1);
    path_bytes.delete();
  endtask

  task automatic drain_verdicts();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_verdicts.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_path(input logic [CNT_W-1:0] limit);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_MAX_PATH;
    pwdata  <= CFG_DW'(limit);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    max_path_len = limit;
    @(posedge clk);
  endtask

  function automatic void add_byte(input logic [7:0] b);
    path_bytes = {path_bytes, b};
  endfunction

  function automatic void add_text(input string s);
    foreach (s[i])
      add_byte(s[i]);
  endfunction

  function automatic void add_utf8(input logic [20:0] cp, input int conts);
    case (conts)
      1: begin
        add_byte({3'b110, cp[10:6]});
        add_byte({2'b10, cp[5:0]});
      end
      2: begin
        add_byte({4'b1110, cp[15:12]});
        add_byte({2'b10, cp[11:6]});
        add_byte({2'b10, cp[5:0]});
      end
      default: begin
        add_byte({5'b11110, cp[20:18]});
        add_byte({2'b10, cp[17:12]});
        add_byte({2'b10, cp[11:6]});
        add_byte({2'b10, cp[5:0]});
      end
    endcase
  endfunction

  function automatic logic [20:0] legal_scalar(input int conts);
    int pick;
    pick = $urandom_range(3);
    case (conts)
      1: return (pick == 0) ? 21'h80 : (pick == 1) ? 21'h7ff : 21'($urandom_range('h80, 'h7ff));
      2: begin
        if (pick == 0)
          return $urandom_range(1) ? 21'h800 : 21'hd7ff;
        if (pick == 1)
          return $urandom_range(1) ? 21'he000 : 21'hffff;
        return $urandom_range(1) ? 21'($urandom_range('h800, 'hd7ff))
                                 : 21'($urandom_range('he000, 'hffff));
      end
      default: return (pick == 0) ? CP_MIN_4B : (pick == 1) ? CP_MAX
                                  : 21'($urandom_range('h10000, 'h10ffff));
    endcase
  endfunction

  function automatic logic [7:0] name_char();
    case ($urandom_range(9))
      0, 1, 2: return 8'($urandom_range(CH_LOW_A, CH_LOW_Z));
      3, 4:    return 8'($urandom_range(CH_LOW_A, CH_LOW_Z)) - 8'h20;
      5:       return 8'($urandom_range(8'h30, CH_NINE));
      6, 7:    return CH_DOT;
      8:       return 8'h2d;
      default: return 8'($urandom_range(8'h20, 8'h7e));
    endcase
  endfunction

  function automatic void add_device_name();
    logic [23:0] dev;
    logic [7:0]  c;
    case ($urandom_range(5))
      0:       dev = DEV_CON;
      1:       dev = DEV_PRN;
      2:       dev = DEV_AUX;
      3:       dev = DEV_NUL;
      4:       dev = DEV_COM;
      default: dev = DEV_LPT;
    endcase
    for (int k = 2; k >= 0; k--) begin
      c = dev[8*k +: 8];
      add_byte($urandom_range(1) ? (c | 8'h20) : c);
    end
    if (dev == DEV_COM || dev == DEV_LPT || $urandom_range(4) == 0)
      add_byte(8'($urandom_range(8'h2f, 8'h3a)));
    case ($urandom_range(4))
      0: begin
        add_byte(CH_DOT);
        repeat ($urandom_range(1, 3)) add_byte(name_char());
      end
      1: add_byte(name_char());
      2: add_byte(CH_DOT);
      default: ;
    endcase
  endfunction

  function automatic void add_bad_utf8();
    int conts;
    conts = $urandom_range(1, 3);
    case ($urandom_range(6))
      0: add_utf8(21'($urandom_range(0, conts == 1 ? 'h7f : conts == 2 ? 'h7ff : 'hffff)),
                  conts);
      1: add_utf8(21'($urandom_range('hd800, 'hdfff)), 2);
      2: add_utf8(21'($urandom_range('h110000, 'h1fffff)), 3);
      3: begin
        add_utf8(legal_scalar(conts), conts);
        repeat ($urandom_range(1, conts)) void'(path_bytes.pop_back());
      end
      4: add_byte(8'h80 | 8'($urandom_range(8'h3f)));
      5: add_byte(8'($urandom_range(8'hf8, 8'hff)));
      default: begin
        add_utf8(legal_scalar(conts), conts);
        void'(path_bytes.pop_back());
        add_byte(name_char());
      end
    endcase
  endfunction

  function automatic void add_component();
    case ($urandom_range(15))
      6: add_device_name();
      7: begin
        if ($urandom_range(1))
          add_byte(name_char());
        repeat ($urandom_range(1, 2)) begin
          int conts;
          conts = $urandom_range(1, 3);
          add_utf8(legal_scalar(conts), conts);
        end
      end
      8: begin
        add_bad_utf8();
        if ($urandom_range(1))
          add_byte(name_char());
      end
      9:  repeat ($urandom_range(1, 2)) add_byte(CH_DOT);
      10: ;
      11: begin
        add_byte(name_char());
        add_byte($urandom_range(1) ? CH_NUL : CH_BSLASH);
      end
      default: repeat ($urandom_range(1, 9)) add_byte(name_char());
    endcase
  endfunction

  function automatic void build_random_path();
    int kind;
    kind = $urandom_range(24);
    if (kind == 0)
      return;
    if (kind <= 2) begin
      repeat ($urandom_range(1, 12)) add_byte(8'($urandom_range(255)));
      return;
    end
    if ($urandom_range(19) == 0)
      add_byte(CH_SLASH);
    for (int k = $urandom_range(1, 4); k > 0; k--) begin
      add_component();
      if (k > 1)
        add_byte(CH_SLASH);
    end
    if ($urandom_range(19) == 0)
      add_byte(CH_SLASH);
  endfunction

  task automatic test_directed();
    send_path(1'b0, 1'b0);
    send_item("a", 1'b1, 1'b0);
    send_item(8'ha5, 1'b0, 1'b0);
    send_item(CH_NUL, 1'b0, 1'b1);
    add_text("/");
    send_path(1'b0, 1'b0);
    add_text("..");
    send_path(1'b0, 1'b0);
    add_text("cOm1");
    send_path(1'b0, 1'b0);
    add_byte(8'hff);
    send_path(1'b0, 1'b0);
    add_byte(CH_NUL);
    send_path(1'b0, 1'b0);
    add_byte(CH_BSLASH);
    send_path(1'b0, 1'b0);
    add_utf8(21'h20ac, 2);
    send_path(1'b0, 1'b0);
    path_bytes = '{8'hc0, 8'h80};
    send_path(1'b0, 1'b0);
    add_byte(8'hf4);
    send_path(1'b0, 1'b0);
    add_utf8(CP_SUR_LO, 2);
    send_path(1'b0, 1'b0);
    drain_verdicts();
  endtask

  task automatic test_length_limits();
    write_max_path(11'd3);
    add_text("abc");
    send_path(1'b0, 1'b0);
    add_text("abcd");
    send_path(1'b0, 1'b0);
    drain_verdicts();
    write_max_path(11'd1);
    add_text("a");
    send_path(1'b0, 1'b0);
    add_text("ab");
    send_path(1'b1, 1'b0);
    drain_verdicts();
    write_max_path(11'd0);
    add_text("a");
    send_path(1'b0, 1'b0);
    drain_verdicts();
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input logic [CNT_W-1:0] limit);
    int goal;
    write_max_path(limit);
    sender_idle_pct = idle_pct;
    sink_stall_pct  = stall_pct;
    goal = path_beats + PHASE_BEATS;
    while (path_beats < goal) begin
      build_random_path();
      send_path($urandom_range(5) == 0, 1'b1);
    end
    drain_verdicts();
    sender_idle_pct = 0;
    sink_stall_pct  = 0;
  endtask

  initial begin
    rst_n              = 1'b0;
    in_if.valid        = 1'b0;
    in_if.char_byte    = '0;
    in_if.byte_present = 1'b0;
    in_if.last_byte    = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    clear_path_state();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_length_limits();
    test_random_traffic(0, 0, 11'($urandom_range(8, 24)));
    test_random_traffic(61, 0, CNT_MAX);
    test_random_traffic(0, 61, 11'($urandom_range(1, 12)));
    test_random_traffic(18, 18, 11'($urandom_range(25, 2047)));

    if (expected_verdicts.size() != 0) begin
      $error("%0d verdicts never arrived", expected_verdicts.size());
      mismatches++;
    end
    $display("Sent %0d path beats and checked %0d verdicts over directed paths,",
             path_beats, verdicts_seen);
    $display("length limits and four idling and stalling patterns.");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
